// ===== rtl/obt_pkg.sv =====
package obt_pkg;

  // default vertex capacity
  localparam int unsigned MaxNodesDef = 1024;

  // fixed field widths
  localparam int unsigned EndpointW = 10;
  localparam int unsigned CountW    = 10;
  localparam int unsigned CfgValW   = 11;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  // register indexes
  localparam logic [0:0] RegNodeCount = 1'b0;

  // result outcome codes
  typedef enum logic [1:0] {
    OUT_IGNORED = 2'd0,
    OUT_BRIDGE  = 2'd1,
    OUT_CYCLE   = 2'd2
  } outcome_e;

  // one result from the sequencer
  typedef struct packed {
    outcome_e            outcome;
    logic [CountW-1:0]   cleared;
    logic [CountW-1:0]   total;
  } obt_res_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_GOT_U,
    ST_GOT_V,
    ST_GOT_TU,
    ST_GOT_TV,
    ST_RR_TOP,
    ST_RR_PAR,
    ST_RR_RE,
    ST_RR_WR,
    ST_RR_CS,
    ST_RR_RT,
    ST_TV_RD,
    ST_TV_WR,
    ST_WALK,
    ST_WALK_M,
    ST_WALK_END,
    ST_CL_START,
    ST_CL_TOP,
    ST_CL_PAR,
    ST_CL_RE,
    ST_CL_WR,
    ST_DONE
  } ctrl_state_e;

endpackage

// ===== rtl/obt_if.sv =====
interface obt_edge_if;
  import obt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [EndpointW-1:0] endpoint_a;
  logic [EndpointW-1:0] endpoint_b;
  modport source (output valid, output endpoint_a, output endpoint_b, input ready);
  modport sink (input valid, input endpoint_a, input endpoint_b, output ready);
endinterface

interface obt_result_if;
  import obt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        outcome;
  logic [CountW-1:0] bridges_cleared;
  logic [CountW-1:0] bridge_total;
  modport source (output valid, output outcome, output bridges_cleared,
                  output bridge_total, input ready);
  modport sink (input valid, input outcome, input bridges_cleared,
                input bridge_total, output ready);
endinterface

// ===== rtl/obt_mem.sv =====
module obt_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/obt_ctrl.sv =====
module obt_ctrl #(
  parameter int unsigned MAX_NODES = obt_pkg::MaxNodesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(MAX_NODES+1)-1:0]       node_count_i,
  input  logic                                 edge_valid_i,
  output logic                                 edge_ready_o,
  input  logic [obt_pkg::EndpointW-1:0]        endpoint_a_i,
  input  logic [obt_pkg::EndpointW-1:0]        endpoint_b_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output obt_pkg::obt_res_t                    res_o
);
  import obt_pkg::*;

  localparam int unsigned NW     = $clog2(MAX_NODES);
  localparam int unsigned PW     = NW + 1;
  localparam int unsigned SW     = $clog2(MAX_NODES + 1);
  localparam int unsigned MW     = 32;
  localparam int unsigned L_MARK = 0;
  localparam int unsigned L_SIZE = MW;
  localparam int unsigned L_CLNK = L_SIZE + SW;
  localparam int unsigned L_BLNK = L_CLNK + NW;
  localparam int unsigned L_PAR  = L_BLNK + NW;
  localparam int unsigned WW     = L_PAR + PW;
  localparam int unsigned CMPW   = (SW > EndpointW) ? SW : EndpointW;
  localparam int unsigned SATW   = (SW > CountW) ? SW : CountW;
  localparam logic [PW-1:0] NIL  = PW'(MAX_NODES);

  // node word accessors
  function automatic logic [PW-1:0] f_par(input logic [WW-1:0] w);
    return w[L_PAR +: PW];
  endfunction
  function automatic logic [NW-1:0] f_blnk(input logic [WW-1:0] w);
    return w[L_BLNK +: NW];
  endfunction
  function automatic logic [NW-1:0] f_clnk(input logic [WW-1:0] w);
    return w[L_CLNK +: NW];
  endfunction
  function automatic logic [SW-1:0] f_size(input logic [WW-1:0] w);
    return w[L_SIZE +: SW];
  endfunction
  function automatic logic [MW-1:0] f_mark(input logic [WW-1:0] w);
    return w[L_MARK +: MW];
  endfunction
  function automatic logic [CountW-1:0] f_sat(input logic [SW-1:0] v);
    logic [SATW-1:0] x;
    x = SATW'(v);
    return (x > SATW'({CountW{1'b1}})) ? {CountW{1'b1}} : x[CountW-1:0];
  endfunction

  ctrl_state_e      state_q, state_d, ret_q, ret_d;
  logic [NW-1:0]    fx_q, fx_d, clr_idx_q, clr_idx_d;
  logic             fsel_q, fsel_d, side_q, side_d;
  logic [PW-1:0]    rt_q, rt_d, cur_q, cur_d, child_q, child_d;
  logic [PW-1:0]    a_q, a_d, b_q, b_d, meet_q, meet_d;
  logic [WW-1:0]    w_q, w_d;
  logic [NW-1:0]    ea_q, ea_d, eb_q, eb_d, u_q, u_d, v_q, v_d;
  logic [NW-1:0]    tu_q, tu_d, tv_q, tv_d, cnt_q, cnt_d;
  logic [SW-1:0]    su_q, su_d, sz_q, sz_d, clr_q, clr_d;
  logic [MW-1:0]    epoch_q, epoch_d;
  outcome_e         outcome_q, outcome_d;

  logic             mem_we, mem_re;
  logic [NW-1:0]    mem_waddr, mem_raddr;
  logic [WW-1:0]    mem_wdata, mem_rdata;

  // shared decode
  logic [NW-1:0]    lnk;
  logic             is_root, edge_ok, walk_nil, cl_stop, rr_par_ok, cl_par_ok;
  logic [PW-1:0]    walk_x;
  logic [PW-1:0]    par_rd;

  assign lnk       = fsel_q ? f_clnk(mem_rdata) : f_blnk(mem_rdata);
  assign is_root   = (lnk == fx_q) || (PW'(lnk) >= NIL);
  assign edge_ok   = (CMPW'(endpoint_a_i) < CMPW'(node_count_i)) &&
                     (CMPW'(endpoint_b_i) < CMPW'(node_count_i));
  assign walk_x    = side_q ? b_q : a_q;
  assign walk_nil  = (walk_x >= NIL);
  assign cl_stop   = (rt_q == meet_q) || (rt_q >= NIL);
  assign par_rd    = f_par(mem_rdata);
  assign rr_par_ok = (par_rd < NIL);
  assign cl_par_ok = rr_par_ok;

  obt_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (WW)
  ) u_obt_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_idx_q == NW'(MAX_NODES - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (edge_valid_i) state_d = edge_ok ? ST_FIND : ST_DONE;
      ST_FIND:     if (is_root) state_d = ret_q;
      ST_GOT_U:    state_d = ST_FIND;
      ST_GOT_V:    state_d = (rt_q[NW-1:0] == u_q) ? ST_DONE : ST_FIND;
      ST_GOT_TU:   state_d = ST_FIND;
      ST_GOT_TV:   state_d = (rt_q[NW-1:0] == tu_q) ? ST_WALK : ST_RR_TOP;
      ST_RR_TOP:   state_d = (cur_q != NIL) ? ST_RR_PAR : ST_RR_CS;
      ST_RR_PAR:   state_d = rr_par_ok ? ST_FIND : ST_RR_RE;
      ST_RR_RE:    state_d = ST_RR_WR;
      ST_RR_WR:    state_d = ST_RR_TOP;
      ST_RR_CS:    state_d = ST_RR_RT;
      ST_RR_RT:    state_d = ST_TV_RD;
      ST_TV_RD:    state_d = ST_TV_WR;
      ST_TV_WR:    state_d = ST_DONE;
      ST_WALK: begin
        if (!walk_nil)   state_d = ST_FIND;
        else if (side_q) state_d = ST_WALK_END;
      end
      ST_WALK_M:   state_d = side_q ? ST_WALK_END : ST_WALK;
      ST_WALK_END: begin
        if (meet_q != NIL)               state_d = ST_CL_START;
        else if (a_q == NIL && b_q == NIL) state_d = ST_DONE;
        else                             state_d = ST_WALK;
      end
      ST_CL_START: state_d = ST_FIND;
      ST_CL_TOP: begin
        if (!cl_stop)   state_d = ST_CL_PAR;
        else if (side_q) state_d = ST_DONE;
        else            state_d = ST_CL_START;
      end
      ST_CL_PAR:   state_d = cl_par_ok ? ST_FIND : ST_CL_RE;
      ST_CL_RE:    state_d = ST_CL_WR;
      ST_CL_WR:    state_d = ST_CL_TOP;
      ST_DONE:     if (res_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory accesses
  always_comb begin
    logic [WW-1:0] wt;
    logic [NW-1:0] tv_n;
    logic [MW-1:0] ep_n;
    wt        = mem_rdata;
    tv_n      = rt_q[NW-1:0];
    ep_n      = epoch_q + MW'(1);
    ret_d     = ret_q;
    fx_d      = fx_q;
    fsel_d    = fsel_q;
    side_d    = side_q;
    clr_idx_d = clr_idx_q;
    rt_d      = rt_q;
    cur_d     = cur_q;
    child_d   = child_q;
    a_d       = a_q;
    b_d       = b_q;
    meet_d    = meet_q;
    w_d       = w_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    u_d       = u_q;
    v_d       = v_q;
    tu_d      = tu_q;
    tv_d      = tv_q;
    cnt_d     = cnt_q;
    su_d      = su_q;
    sz_d      = sz_q;
    clr_d     = clr_q;
    epoch_d   = epoch_q;
    outcome_d = outcome_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = {NIL, clr_idx_q, clr_idx_q, SW'(1), MW'(0)};
        clr_idx_d = clr_idx_q + NW'(1);
      end
      ST_IDLE: begin
        if (edge_valid_i) begin
          ea_d      = NW'(endpoint_a_i);
          eb_d      = NW'(endpoint_b_i);
          clr_d     = '0;
          outcome_d = OUT_IGNORED;
          fx_d      = NW'(endpoint_a_i);
          fsel_d    = 1'b0;
          ret_d     = ST_GOT_U;
          mem_re    = edge_ok;
          mem_raddr = NW'(endpoint_a_i);
        end
      end
      ST_FIND: begin
        if (is_root) begin
          rt_d = {1'b0, fx_q};
          w_d  = mem_rdata;
        end else begin
          fx_d      = lnk;
          mem_re    = 1'b1;
          mem_raddr = lnk;
        end
      end
      ST_GOT_U: begin
        u_d       = rt_q[NW-1:0];
        fx_d      = eb_q;
        fsel_d    = 1'b0;
        ret_d     = ST_GOT_V;
        mem_re    = 1'b1;
        mem_raddr = eb_q;
      end
      ST_GOT_V: begin
        v_d       = rt_q[NW-1:0];
        fx_d      = u_q;
        fsel_d    = 1'b1;
        ret_d     = ST_GOT_TU;
        mem_re    = (rt_q[NW-1:0] != u_q);
        mem_raddr = u_q;
      end
      ST_GOT_TU: begin
        tu_d      = rt_q[NW-1:0];
        su_d      = f_size(w_q);
        fx_d      = v_q;
        fsel_d    = 1'b1;
        ret_d     = ST_GOT_TV;
        mem_re    = 1'b1;
        mem_raddr = v_q;
      end
      ST_GOT_TV: begin
        if (rt_q[NW-1:0] == tu_q) begin
          // cycle: fresh walk epoch, zero is reserved for unvisited
          epoch_d = (ep_n == '0) ? MW'(1) : ep_n;
          a_d     = {1'b0, u_q};
          b_d     = {1'b0, v_q};
          meet_d  = NIL;
          side_d  = 1'b0;
        end else begin
          // new bridge: smaller tree is re-rooted and hung under the other
          cnt_d     = cnt_q + NW'(1);
          outcome_d = OUT_BRIDGE;
          child_d   = NIL;
          if (su_q > f_size(w_q)) begin
            u_d   = v_q;
            v_d   = u_q;
            tv_d  = tu_q;
            cur_d = {1'b0, v_q};
          end else begin
            tv_d  = tv_n;
            cur_d = {1'b0, u_q};
          end
        end
      end
      ST_RR_TOP: begin
        mem_re    = 1'b1;
        mem_raddr = (cur_q != NIL) ? cur_q[NW-1:0] : child_q[NW-1:0];
      end
      ST_RR_PAR: begin
        fx_d   = par_rd[NW-1:0];
        fsel_d = 1'b0;
        ret_d  = ST_RR_RE;
        if (rr_par_ok) begin
          mem_re    = 1'b1;
          mem_raddr = par_rd[NW-1:0];
        end else begin
          rt_d = NIL;
        end
      end
      ST_RR_RE: begin
        mem_re    = 1'b1;
        mem_raddr = cur_q[NW-1:0];
      end
      ST_RR_WR: begin
        wt[L_PAR +: PW]  = child_q;
        wt[L_CLNK +: NW] = u_q;
        mem_we           = 1'b1;
        mem_waddr        = cur_q[NW-1:0];
        mem_wdata        = wt;
        child_d          = cur_q;
        cur_d            = rt_q;
      end
      ST_RR_CS: begin
        sz_d      = f_size(mem_rdata);
        mem_re    = 1'b1;
        mem_raddr = u_q;
      end
      ST_RR_RT: begin
        wt[L_PAR +: PW]  = {1'b0, v_q};
        wt[L_CLNK +: NW] = v_q;
        wt[L_SIZE +: SW] = sz_q;
        mem_we           = 1'b1;
        mem_waddr        = u_q;
        mem_wdata        = wt;
      end
      ST_TV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = tv_q;
      end
      ST_TV_WR: begin
        wt[L_SIZE +: SW] = f_size(mem_rdata) + sz_q;
        mem_we           = 1'b1;
        mem_waddr        = tv_q;
        mem_wdata        = wt;
      end
      ST_WALK: begin
        if (walk_nil) begin
          if (side_q) b_d = NIL;
          else        a_d = NIL;
          side_d = 1'b1;
        end else begin
          fx_d      = walk_x[NW-1:0];
          fsel_d    = 1'b0;
          ret_d     = ST_WALK_M;
          mem_re    = 1'b1;
          mem_raddr = walk_x[NW-1:0];
        end
      end
      ST_WALK_M: begin
        if (f_mark(w_q) == epoch_q) meet_d = rt_q;
        wt                = w_q;
        wt[L_MARK +: MW]  = epoch_q;
        mem_we            = 1'b1;
        mem_waddr         = rt_q[NW-1:0];
        mem_wdata         = wt;
        if (side_q) b_d = f_par(w_q);
        else        a_d = f_par(w_q);
        side_d = 1'b1;
      end
      ST_WALK_END: begin
        side_d = 1'b0;
      end
      ST_CL_START: begin
        fx_d      = side_q ? v_q : u_q;
        fsel_d    = 1'b0;
        ret_d     = ST_CL_TOP;
        mem_re    = 1'b1;
        mem_raddr = side_q ? v_q : u_q;
      end
      ST_CL_TOP: begin
        if (!cl_stop) begin
          cur_d     = rt_q;
          mem_re    = 1'b1;
          mem_raddr = rt_q[NW-1:0];
        end else if (side_q) begin
          outcome_d = OUT_CYCLE;
          cnt_d     = (clr_q > SW'(cnt_q)) ? '0 : NW'(SW'(cnt_q) - clr_q);
        end else begin
          side_d = 1'b1;
        end
      end
      ST_CL_PAR: begin
        fx_d   = par_rd[NW-1:0];
        fsel_d = 1'b0;
        ret_d  = ST_CL_RE;
        if (cl_par_ok) begin
          mem_re    = 1'b1;
          mem_raddr = par_rd[NW-1:0];
        end else begin
          rt_d = NIL;
        end
      end
      ST_CL_RE: begin
        mem_re    = 1'b1;
        mem_raddr = cur_q[NW-1:0];
      end
      ST_CL_WR: begin
        wt[L_BLNK +: NW] = meet_q[NW-1:0];
        mem_we           = 1'b1;
        mem_waddr        = cur_q[NW-1:0];
        mem_wdata        = wt;
        clr_d            = clr_q + SW'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
      epoch_q   <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      epoch_q   <= epoch_d;
      cnt_q     <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    fx_q      <= fx_d;
    fsel_q    <= fsel_d;
    side_q    <= side_d;
    rt_q      <= rt_d;
    cur_q     <= cur_d;
    child_q   <= child_d;
    a_q       <= a_d;
    b_q       <= b_d;
    meet_q    <= meet_d;
    w_q       <= w_d;
    ea_q      <= ea_d;
    eb_q      <= eb_d;
    u_q       <= u_d;
    v_q       <= v_d;
    tu_q      <= tu_d;
    tv_q      <= tv_d;
    su_q      <= su_d;
    sz_q      <= sz_d;
    clr_q     <= clr_d;
    outcome_q <= outcome_d;
  end

  assign edge_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o   = (state_q == ST_DONE);
  assign res_o.outcome = outcome_q;
  assign res_o.cleared = f_sat(clr_q);
  assign res_o.total   = f_sat(SW'(cnt_q));

endmodule

// ===== rtl/online_bridge_tracker.sv =====
// Online bridge tracker: takes undirected edges one per input transfer and
// returns one result per edge (ignored, new bridge or cycle merged, with the
// bridges cleared and the running bridge count). All per-vertex state lives
// in one node memory with a single read and a single write port. An edge with
// an endpoint out of range is ignored. Otherwise four union-find root searches
// find the blocks and trees of both endpoints (two searches when both
// endpoints already share a block). A new bridge then re-roots the smaller
// tree, reading and rewriting each block on the path with a parent search for
// each, and hangs it under the other. A closed cycle walks both sides upward,
// with a root search per step of each side, until they meet, then collapses
// the path: a root search per side and a parent search for each block merged.
// Links are not compressed, so long merge chains cost more.
// After reset the memory is initialised one vertex per cycle, and no edge is
// taken until that is done; the node_count register may be written at any
// time and only limits which endpoints are accepted.
module online_bridge_tracker #(
  parameter int unsigned MAX_NODES = obt_pkg::MaxNodesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  obt_edge_if.sink                      edge_i,
  obt_result_if.source                  result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [obt_pkg::ApbAddrW-1:0]  paddr,
  input  logic [obt_pkg::ApbDataW-1:0]  pwdata,
  output logic [obt_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import obt_pkg::*;

  localparam int unsigned SW = $clog2(MAX_NODES + 1);
  localparam int unsigned KW = (SW > CfgValW) ? SW : CfgValW;
  localparam int unsigned NcReset = (MAX_NODES < 1024) ? MAX_NODES : 1024;

  logic [SW-1:0]      node_count_q, node_count_d;
  logic               cfg_wr, res_valid, res_ready, out_valid_q;
  logic [KW-1:0]      cfg_val;
  obt_res_t           res, out_q;

  // configuration write with clamping
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == RegNodeCount);
  assign cfg_val = KW'(pwdata[CfgValW-1:0]);

  always_comb begin
    node_count_d = node_count_q;
    if (cfg_wr) begin
      if (cfg_val == '0)                   node_count_d = SW'(1);
      else if (cfg_val > KW'(MAX_NODES))   node_count_d = SW'(MAX_NODES);
      else                                 node_count_d = SW'(cfg_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= SW'(NcReset);
    end else begin
      node_count_q <= node_count_d;
    end
  end

  assign prdata = (paddr[2] == RegNodeCount) ? ApbDataW'(node_count_q) : '0;

  obt_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_obt_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .edge_valid_i (edge_i.valid),
    .edge_ready_o (edge_i.ready),
    .endpoint_a_i (edge_i.endpoint_a),
    .endpoint_b_i (edge_i.endpoint_b),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register, loads when empty or being drained
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.outcome         = out_q.outcome;
  assign result_o.bridges_cleared = out_q.cleared;
  assign result_o.bridge_total    = out_q.total;

endmodule

// ===== rtl/obt_checker.sv =====
module obt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  outcome_i,
  input logic [9:0]  cleared_i,
  input logic [9:0]  total_i
);
  import obt_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // only the three outcome codes appear
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (outcome_i == OUT_IGNORED || outcome_i == OUT_BRIDGE ||
                     outcome_i == OUT_CYCLE))
    else $error("bad outcome code");

  // bridges are cleared only by a merged cycle
  a_clear_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i != OUT_CYCLE) |-> (cleared_i == '0))
    else $error("bridges cleared without a cycle");

  // a new bridge leaves at least one bridge
  a_bridge_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (outcome_i == OUT_BRIDGE) |-> (total_i != '0))
    else $error("bridge count zero after new bridge");

endmodule

bind online_bridge_tracker obt_checker u_obt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .outcome_i   (result_o.outcome),
  .cleared_i   (result_o.bridges_cleared),
  .total_i     (result_o.bridge_total)
);

// ===== verif/obt_checker.sv =====
module obt_scoreboard #(
  parameter int unsigned NODES = obt_pkg::MaxNodesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  obt_edge_if                          edge_mon,
  obt_result_if                        res_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [obt_pkg::ApbAddrW-1:0] paddr,
  input  logic [obt_pkg::ApbDataW-1:0] pwdata,
  input  logic                         pready,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import obt_pkg::*;

  localparam int unsigned NilNode = NODES;

  typedef struct packed {
    outcome_e          outcome;
    logic [CountW-1:0] cleared;
    logic [CountW-1:0] total;
  } bridge_result_t;

  // mirrored graph state
  int unsigned    par_q    [NODES];
  int unsigned    blk_q    [NODES];
  int unsigned    comp_q   [NODES];
  int unsigned    size_q   [NODES];
  int unsigned    mark_q   [NODES];
  int unsigned    epoch_q;
  int unsigned    bridges_q;
  int unsigned    limit_q;
  bridge_result_t expected_q[$];

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // union-find root search with path compression, on blocks or components
  function automatic int unsigned root_of(input bit on_comp, input int unsigned x);
    int unsigned r, nxt, guard;
    if (x >= NODES) return NilNode;
    r = x;
    guard = 0;
    while ((on_comp ? comp_q[r] : blk_q[r]) != r && guard < NODES) begin
      nxt = on_comp ? comp_q[r] : blk_q[r];
      if (nxt >= NODES) break;
      r = nxt;
      guard++;
    end
    guard = 0;
    while (x != r && guard < NODES) begin
      nxt = on_comp ? comp_q[x] : blk_q[x];
      if (on_comp) comp_q[x] = r;
      else blk_q[x] = r;
      if (nxt >= NODES) break;
      x = nxt;
      guard++;
    end
    return r;
  endfunction

  // turn the tree of u around so that u becomes its root
  function automatic void hang_from(input int unsigned u);
    int unsigned top, child, p, guard;
    child = NilNode;
    guard = 0;
    u = root_of(1'b0, u);
    top = u;
    while (u != NilNode && guard <= NODES) begin
      p = root_of(1'b0, par_q[u]);
      par_q[u] = child;
      comp_q[u] = top;
      child = u;
      u = p;
      guard++;
    end
    if (child < NODES && top < NODES) size_q[top] = size_q[child];
  endfunction

  function automatic int unsigned fold_path(input int unsigned x, input int unsigned meet);
    int unsigned cnt, guard, nxt;
    cnt = 0;
    guard = 0;
    x = root_of(1'b0, x);
    while (x != meet && x < NODES && guard < NODES) begin
      nxt = root_of(1'b0, par_q[x]);
      blk_q[x] = meet;
      cnt++;
      x = nxt;
      guard++;
    end
    return cnt;
  endfunction

  // walk both paths to their meeting block and merge them
  function automatic bit close_loop(input int unsigned u, input int unsigned v,
                                    output int unsigned cleared);
    int unsigned meet, a, b, guard;
    meet = NilNode;
    a = u;
    b = v;
    guard = 0;
    cleared = 0;
    epoch_q++;
    if (epoch_q == 0) epoch_q = 1;
    while (meet == NilNode && guard <= 2 * NODES) begin
      if (a == NilNode && b == NilNode) return 1'b0;
      if (a != NilNode) begin
        a = root_of(1'b0, a);
        if (a < NODES) begin
          if (mark_q[a] == epoch_q) meet = a;
          mark_q[a] = epoch_q;
          a = par_q[a];
        end else a = NilNode;
      end
      if (b != NilNode) begin
        b = root_of(1'b0, b);
        if (b < NODES) begin
          if (mark_q[b] == epoch_q) meet = b;
          mark_q[b] = epoch_q;
          b = par_q[b];
        end else b = NilNode;
      end
      guard++;
    end
    if (meet == NilNode) return 1'b0;
    cleared = fold_path(u, meet) + fold_path(v, meet);
    blk_q[meet] = meet;
    return 1'b1;
  endfunction

  function automatic bridge_result_t predict_edge(input int unsigned ea, input int unsigned eb);
    bridge_result_t r;
    int unsigned u, v, tu, tv, t, cleared;
    r.outcome = OUT_IGNORED;
    cleared = 0;
    if (ea < limit_q && eb < limit_q) begin
      u = root_of(1'b0, ea);
      v = root_of(1'b0, eb);
      if (u != v && u < NODES && v < NODES) begin
        tu = root_of(1'b1, u);
        tv = root_of(1'b1, v);
        if (tu == tv) begin
          if (close_loop(u, v, cleared)) begin
            r.outcome = OUT_CYCLE;
            bridges_q = (cleared > bridges_q) ? 0 : bridges_q - cleared;
          end
        end else if (tu < NODES && tv < NODES) begin
          r.outcome = OUT_BRIDGE;
          bridges_q++;
          // smaller tree goes under the larger
          if (size_q[tu] > size_q[tv]) begin
            t = u; u = v; v = t;
            t = tu; tu = tv; tv = t;
          end
          hang_from(u);
          par_q[u] = v;
          comp_q[u] = v;
          size_q[tv] += size_q[u];
        end
      end
    end
    r.cleared = (cleared > 1023) ? 10'd1023 : cleared[CountW-1:0];
    r.total   = (bridges_q > 1023) ? 10'd1023 : bridges_q[CountW-1:0];
    return r;
  endfunction

  // watch transfers, predict and compare
  always @(posedge clk_i or negedge rst_ni) begin
    bridge_result_t want;
    int unsigned    val;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        par_q[i]  = NilNode;
        blk_q[i]  = i;
        comp_q[i] = i;
        size_q[i] = 1;
        mark_q[i] = 0;
      end
      epoch_q      = 0;
      bridges_q    = 0;
      limit_q      = NODES;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ApbAddrW'(4 * RegNodeCount)) begin
        val = pwdata & 32'h7ff;
        if (val < 1) val = 1;
        if (val > NODES) val = NODES;
        limit_q = val;
      end
      if (edge_mon.valid && edge_mon.ready)
        expected_q.push_back(predict_edge(edge_mon.endpoint_a, edge_mon.endpoint_b));
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result transfer", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (res_mon.outcome !== want.outcome)
            report("outcome", res_mon.outcome, want.outcome);
          if (res_mon.bridges_cleared !== want.cleared)
            report("bridges_cleared", res_mon.bridges_cleared, want.cleared);
          if (res_mon.bridge_total !== want.total)
            report("bridge_total", res_mon.bridge_total, want.total);
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import obt_pkg::*;

  localparam int unsigned WatchLimit = 200000;
  localparam int unsigned SettleCycles = 5000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         quiet_cycles;
  bit                  no_gaps;

  obt_edge_if   edge_ch ();
  obt_result_if res_ch ();

  online_bridge_tracker u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_ch),
    .result_o (res_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  obt_scoreboard u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_mon     (edge_ch),
    .res_mon      (res_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none during a burst
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_ch.ready <= 1'b0;
    else res_ch.ready <= (pick_gap() == 0);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("online_bridge_tracker test failed");
      $finish;
    end
  end

  task automatic send_edge(input int unsigned a, input int unsigned b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      edge_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    edge_ch.valid      <= 1'b1;
    edge_ch.endpoint_a <= a[EndpointW-1:0];
    edge_ch.endpoint_b <= b[EndpointW-1:0];
    do @(posedge clk_i); while (!edge_ch.ready);
    @(negedge clk_i);
  endtask

  // wait for every result, ignored edges included, then wait SettleCycles more
  task automatic drain();
    edge_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_node_count(input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * RegNodeCount);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random edges, mostly inside small windows so that cycles close often
  task automatic random_phase(input int unsigned count, input int unsigned lim);
    int unsigned base, span;
    base = 0;
    span = 2;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        span = $urandom_range(2, 24);
        base = $urandom_range(0, 1024 - span);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) == 0)
        send_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (lim < 1024 && $urandom_range(0, 1) == 0)
        send_edge($urandom_range(0, lim - 1), $urandom_range(0, lim - 1));
      else
        send_edge(base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int unsigned lim;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    edge_ch.valid      = 1'b0;
    edge_ch.endpoint_a = '0;
    edge_ch.endpoint_b = '0;
    no_gaps            = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero clamps to one vertex: only the self loop at vertex 0 is in range
    write_node_count(0);
    send_edge(0, 0);
    send_edge(0, 1);
    send_edge(1023, 1023);
    drain();

    // all ones clamps to the full capacity
    write_node_count(11'h7ff);
    send_edge(5, 6);
    send_edge(6, 7);
    send_edge(7, 5);
    send_edge(5, 6);
    send_edge(9, 9);
    send_edge(1023, 1022);
    send_edge(0, 1023);
    // long chain, then one edge closing it
    for (int i = 100; i < 111; i++) send_edge(i, i + 1);
    send_edge(111, 100);
    send_edge(1022, 0);
    drain();

    write_node_count(1024);
    random_phase(400, 1024);
    drain();

    lim = $urandom_range(100, 600);
    write_node_count(lim);
    random_phase(350, lim);
    drain();

    write_node_count(1024);
    random_phase(380, 1024);
    drain();

    if (fail_count == 0) begin
      $display("online_bridge_tracker test passed");
    end else begin
      $display("online_bridge_tracker test failed");
    end
    $finish;
  end

endmodule
